/* rtl/mdnep_pkg.sv */
// shared types, constants and the drum note map for the midi drum note parser
// no dependencies
package mdnep_pkg;

	// event codes carried by one result item
	typedef logic [2:0] event_code_t;

	localparam event_code_t EV_LEFT   = 3'd0;
	localparam event_code_t EV_RIGHT  = 3'd1;
	localparam event_code_t EV_CW     = 3'd2;
	localparam event_code_t EV_CCW    = 3'd3;
	localparam event_code_t EV_DROP   = 3'd4;
	localparam event_code_t EV_PAUSE  = 3'd5;
	localparam event_code_t EV_NONE   = 3'd7;

	// status byte high nibbles
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_POLY_AT  = 4'hA;
	localparam logic [3:0] NIB_CONTROL  = 4'hB;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
	localparam logic [3:0] NIB_BEND     = 4'hE;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	// system exclusive framing
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;

	// data bytes still owed to the current message
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// default depth of the event queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// queue status seen by the front and back
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// drum map: note number to event code, EV_NONE where unmapped
	function automatic event_code_t map_note(input logic [7:0] note);
		event_code_t ev;
		case (note)
			8'h23, 8'h24, 8'h2C:                      ev = EV_DROP;
			8'h25, 8'h26, 8'h27, 8'h28:               ev = EV_LEFT;
			8'h29, 8'h2B:                             ev = EV_RIGHT;
			8'h2D, 8'h2F:                             ev = EV_CW;
			8'h30, 8'h32:                             ev = EV_CCW;
			8'h31, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
			8'h39, 8'h3B:                             ev = EV_PAUSE;
			default:                                  ev = EV_NONE;
		endcase
		return ev;
	endfunction

endpackage

/* rtl/midi_drum_note_event_parser.sv */
// midi drum note parser: one byte accepted per cycle, in_ready drops only when
// the event queue is full. an event is written into the queue at the accepting
// edge of its velocity byte, then moves into the output register once that is free or taken.
// sustained rate is one byte per cycle unless the queue is full (combinational parse step).
// asynchronous active-low reset returns the parser to idle and empties the queue.
module midi_drum_note_event_parser
	import mdnep_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_code
);

	q_stat_t     q_stat;
	logic        push;
	logic        pop;
	event_code_t push_code;
	event_code_t head_code;

	// byte parser
	mdnep_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.q_stat        (q_stat),
		.push          (push),
		.push_code     (push_code)
	);

	// decoupling queue
	mdnep_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_code (push_code),
		.pop       (pop),
		.head_code (head_code),
		.q_stat    (q_stat)
	);

	// output stage
	mdnep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_code  (head_code),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code)
	);

endmodule

/* rtl/mdnep_front.sv */
// front end: accepts midi bytes, tracks message state, pushes drum events
// depends on mdnep_pkg
module mdnep_front
	import mdnep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  q_stat_t     q_stat,
	output logic        push,
	output event_code_t push_code
);

	logic [1:0] pending_q;
	logic       note_on_q;
	logic [7:0] held_note_q;
	logic       sysex_q;

	logic [1:0] pending_d;
	logic       note_on_d;
	logic [7:0] held_note_d;
	logic       sysex_d;
	logic       accept;
	logic       hit;
	event_code_t mapped;

	// a full queue is the only thing that stalls the front
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign mapped   = map_note(held_note_q);

	// next message state for one byte
	always_comb begin
		pending_d   = pending_q;
		note_on_d   = note_on_q;
		held_note_d = held_note_q;
		sysex_d     = sysex_q;
		hit         = 1'b0;
		if (sysex_q) begin
			if (data_byte == SYSEX_END || end_of_buffer) begin
				sysex_d = 1'b0;
			end
		end else if (pending_q == PEND_ONE) begin
			// last data byte: velocity for a note-on
			hit       = note_on_q && (data_byte != 8'd0) && (mapped != EV_NONE);
			pending_d = PEND_NONE;
			note_on_d = 1'b0;
		end else begin
			if (pending_q == PEND_TWO) begin
				if (note_on_q) begin
					held_note_d = data_byte;
				end
				pending_d = PEND_ONE;
			end else begin
				case (data_byte[7:4])
					NIB_NOTE_OFF, NIB_POLY_AT, NIB_CONTROL: begin
						pending_d = PEND_TWO;
						note_on_d = 1'b0;
					end
					NIB_NOTE_ON: begin
						pending_d = PEND_TWO;
						note_on_d = 1'b1;
					end
					NIB_PROGRAM, NIB_CHAN_AT, NIB_BEND: begin
						pending_d = PEND_ONE;
						note_on_d = 1'b0;
					end
					NIB_SYSTEM: begin
						if (data_byte == SYSEX_START) begin
							sysex_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			// buffer ends before the message does
			if (end_of_buffer) begin
				pending_d = PEND_NONE;
				note_on_d = 1'b0;
				sysex_d   = 1'b0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= PEND_NONE;
			note_on_q   <= 1'b0;
			held_note_q <= 8'd0;
			sysex_q     <= 1'b0;
		end else if (accept) begin
			pending_q   <= pending_d;
			note_on_q   <= note_on_d;
			held_note_q <= held_note_d;
			sysex_q     <= sysex_d;
		end
	end

	assign push      = accept && hit;
	assign push_code = mapped;

endmodule

/* rtl/mdnep_queue.sv */
// small event queue between front and back, flop based
// depends on mdnep_pkg
module mdnep_queue
	import mdnep_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  event_code_t push_code,
	input  logic        pop,
	output event_code_t head_code,
	output q_stat_t     q_stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	event_code_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_code;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_code    = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == FullCnt);

endmodule

/* rtl/mdnep_back.sv */
// back end: output register that presents one event item at a time
// depends on mdnep_pkg
module mdnep_back
	import mdnep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_stat_t     q_stat,
	input  event_code_t head_code,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output event_code_t event_code
);

	logic        valid_q;
	event_code_t code_q;

	// refill when the register is empty or being taken
	assign pop = !q_stat.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= head_code;
		end
	end

	assign out_valid  = valid_q;
	assign event_code = code_q;

endmodule

/* rtl/mdnep_checker.sv */
// port-level checks for the midi drum note parser, bound to the top level
// depends on mdnep_pkg
module mdnep_checker
	import mdnep_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_code
);

	// a stalled item holds its code
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code))
		else $error("output item changed while stalled");

	// only real event codes leave the block
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= EV_PAUSE))
		else $error("event code out of range");

	// the input stalls only behind a waiting output item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output pending");

	// after a stall with the output taken, the input opens again
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input stayed stalled after output was taken");

endmodule

bind midi_drum_note_event_parser mdnep_checker u_mdnep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_code (event_code)
);

/* sim/midi_drum_note_event_parser_test.sv */
// self-checking test of midi_drum_note_event_parser: drives midi byte streams and
// compares every drum event against a parser model kept in the test
// depends on rtl/mdnep_pkg.sv and rtl/midi_drum_note_event_parser.sv
module midi_drum_note_event_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mdnep_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 400;

	// parser model and queue of drum events still owed by the block
	class drum_event_tracker;
		logic [1:0]  owed;
		bit          note_msg;
		logic [7:0]  note_seen;
		bit          skipping;
		event_code_t due_events[$];
		event_code_t kit[25];
		int          errors;

		function new();
			owed = PEND_NONE;
			note_msg = 0;
			note_seen = 8'h00;
			skipping = 0;
			errors = 0;
			// notes 0x23 up to 0x3b
			kit = '{EV_DROP, EV_DROP, EV_LEFT, EV_LEFT, EV_LEFT, EV_LEFT, EV_RIGHT,
				EV_NONE, EV_RIGHT, EV_DROP, EV_CW, EV_NONE, EV_CW,
				EV_CCW, EV_PAUSE, EV_CCW, EV_PAUSE, EV_PAUSE, EV_PAUSE, EV_PAUSE,
				EV_PAUSE, EV_NONE, EV_PAUSE, EV_NONE, EV_PAUSE};
		endfunction

		function event_code_t drum_for(logic [7:0] note);
			if (note < 8'h23 || note > 8'h3b)
				return EV_NONE;
			return kit[note - 8'h23];
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// advance the model by one accepted input item
		function void note_byte(logic [7:0] b, bit eob);
			event_code_t ev;
			if (skipping) begin
				if (b == SYSEX_END || eob)
					skipping = 0;
				return;
			end
			if (owed == PEND_TWO) begin
				if (note_msg)
					note_seen = b;
				owed = PEND_ONE;
			end else if (owed == PEND_ONE) begin
				if (note_msg && b != 8'h00) begin
					ev = drum_for(note_seen);
					if (ev != EV_NONE)
						due_events.push_back(ev);
				end
				owed = PEND_NONE;
				note_msg = 0;
				return;
			end else begin
				case (b[7:4])
					NIB_NOTE_OFF, NIB_POLY_AT, NIB_CONTROL: begin
						owed = PEND_TWO;
						note_msg = 0;
					end
					NIB_NOTE_ON: begin
						owed = PEND_TWO;
						note_msg = 1;
					end
					NIB_PROGRAM, NIB_CHAN_AT, NIB_BEND: begin
						owed = PEND_ONE;
						note_msg = 0;
					end
					NIB_SYSTEM: begin
						if (b == SYSEX_START)
							skipping = 1;
					end
					default: ;
				endcase
			end
			// buffer ended before the message did
			if (eob) begin
				owed = PEND_NONE;
				note_msg = 0;
				skipping = 0;
			end
		endfunction

		task check_event(logic [2:0] got);
			event_code_t want;
			if (due_events.size() == 0) begin
				report($sformatf("unexpected event %0d", got));
				return;
			end
			want = due_events.pop_front();
			if (got !== want)
				report($sformatf("event_code %0d, expected %0d", got, want));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] event_code;

	drum_event_tracker tracker = new();
	int send_idle;
	int recv_idle;
	bit hold_req;
	int quiet;

	midi_drum_note_event_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_code(event_code)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result check and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_event(event_code);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function bit rand_eob();
		return $urandom_range(19) == 0;
	endfunction

	// offer one item, called at a falling edge, returns at a falling edge
	task send_item(logic [7:0] b, bit eob);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (!in_ready);
		tracker.note_byte(b, eob);
		@(negedge clk);
	endtask

	// well-formed messages with random content, broken ones and noise
	task random_stream(int count);
		int sent;
		int pick;
		int n;
		logic [7:0] b;
		logic [3:0] nib;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// note-on, mostly around the drum map
				send_item({NIB_NOTE_ON, 4'($urandom_range(15))}, rand_eob());
				b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(8'h3c, 8'h22));
				send_item(b, rand_eob());
				b = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
				send_item(b, rand_eob());
				sent += 3;
			end else if (pick < 70) begin
				case ($urandom_range(5))
					0: nib = NIB_NOTE_OFF;
					1: nib = NIB_POLY_AT;
					2: nib = NIB_CONTROL;
					3: nib = NIB_PROGRAM;
					4: nib = NIB_CHAN_AT;
					default: nib = NIB_BEND;
				endcase
				n = (nib == NIB_PROGRAM || nib == NIB_CHAN_AT || nib == NIB_BEND) ? 1 : 2;
				send_item({nib, 4'($urandom_range(15))}, rand_eob());
				repeat (n) send_item(8'($urandom_range(255)), rand_eob());
				sent += n + 1;
			end else if (pick < 80) begin
				// sysex with random body
				n = $urandom_range(4);
				send_item(SYSEX_START, rand_eob());
				repeat (n) send_item(8'($urandom_range(255)), rand_eob());
				send_item(SYSEX_END, rand_eob());
				sent += n + 2;
			end else begin
				send_item(8'($urandom_range(255)), rand_eob());
				sent++;
			end
		end
	endtask

	// main sequence
	initial begin
		logic [8:0] opening[25];
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_buffer = 1'b0;
		send_idle = 19;
		recv_idle = 57;
		hold_req = 0;
		quiet = 0;
		// bit 8 flags the last byte of a buffer
		opening = '{
			9'h090, 9'h023, 9'h001,   // lowest mapped note, velocity one
			9'h09f, 9'h03b, 9'h0ff,   // highest mapped note, velocity with top bit
			9'h090, 9'h02a, 9'h040,   // unmapped hole in the map
			9'h095, 9'h031, 9'h000,   // zero velocity acts as note-off
			9'h0b0, 9'h007, 9'h07f,   // controller swallows two bytes
			9'h080, 9'h13c, 9'h029,   // buffer ends inside a message
			9'h0f0, 9'h07f, 9'h0f7,   // sysex skipped through its end
			9'h0f0, 9'h112,           // buffer ends inside a sysex
			9'h0fe, 9'h000            // lone bytes while idle
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_item(opening[i][7:0], opening[i][8]);
		random_stream(PHASE_ITEMS);

		send_idle = 57;
		recv_idle = 19;
		random_stream(PHASE_ITEMS);

		send_idle = 0;
		recv_idle = 0;
		// long receiver hold-off while notes from the low end of the drum map keep coming
		hold_req = 1;
		repeat (12) begin
			send_item({NIB_NOTE_ON, 4'($urandom_range(15))}, 1'b0);
			send_item(8'($urandom_range(8'h2d, 8'h23)), 1'b0);
			send_item(8'($urandom_range(8'h7f, 8'h01)), 1'b0);
		end
		random_stream(PHASE_ITEMS);
		in_valid <= 1'b0;

		while (tracker.due_events.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
